/* hw/rtl/assert_macros.svh */
// Assertion macros used by the scanner RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/amss_pkg.sv */
// Types, constants and segment table for the millivolt seven-segment scanner
`timescale 1ns / 1ps
package amss_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned MvW      = 14;
  localparam int unsigned AdcBits  = 10;
  localparam int unsigned ConvMax  = (1 << AdcBits) - 1;
  localparam int unsigned ProdW    = SampleW + MvW;
  localparam int unsigned QuotW    = ProdW - AdcBits + 1;
  localparam int unsigned RecipW   = 25;
  localparam int unsigned RecipShift = ProdW + RecipW - QuotW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'((64'd1 << RecipShift) / 64'(ConvMax));

  localparam logic [MvW-1:0] FullScaleReset = MvW'(5000);
  localparam logic [MvW-1:0] MvLimit        = MvW'(9999);
  localparam logic [MvW-1:0] PlaceTens      = MvW'(10);
  localparam logic [MvW-1:0] PlaceHundreds  = MvW'(100);
  localparam logic [MvW-1:0] PlaceThousands = MvW'(1000);

  // exact reciprocals for values below 2^14
  localparam logic [15:0] Div10Mul   = 16'd52429;
  localparam int unsigned Div10Shift = 19;
  localparam logic [12:0] Div100Mul  = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  localparam logic [14:0] Div1000Mul = 15'd16778;
  localparam int unsigned Div1000Shift = 24;

  typedef enum logic [0:0] {
    CmdTick   = 1'b0,
    CmdSample = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    PosUnits     = 2'd0,
    PosTens      = 2'd1,
    PosHundreds  = 2'd2,
    PosThousands = 2'd3
  } pos_e;

  typedef struct packed {
    cmd_e               command;
    logic [SampleW-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [7:0] segments;
    logic [3:0] digit_enable;
    logic [1:0] digit_index;
  } out_word_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

/* hw/rtl/adc_millivolt_seven_segment_scanner_unit.sv */
// Millivolt seven-segment scanner: sample scaling, digit split and scan output
// A tick word passes the input register and the multiply and divide stages into the output register.
// A sample word gives no output; the new value is seen by any later tick.
// Throughput: one word per cycle while the output is not stalled, through a three-stage pipeline
// (input register, multiply, divide by the converter maximum) and an output register.
// Reset clears all valids, the value to 0, the scan to units and full scale to 5000.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module adc_millivolt_seven_segment_scanner_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  amss_pkg::in_word_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output amss_pkg::out_word_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [amss_pkg::MvW-1:0]  cfg_data_i
);
  import amss_pkg::*;

  logic               a_valid_q, a_valid_d;
  cmd_e               a_cmd_q;
  logic [SampleW-1:0] a_sample_q;
  logic               b_valid_q, b_valid_d;
  cmd_e               b_cmd_q;
  logic [ProdW-1:0]   b_prod_q;
  logic               c_valid_q, c_valid_d;
  cmd_e               c_cmd_q;
  logic               out_valid_q, out_valid_d;
  out_word_t          out_data_q, out_data_d;

  logic [MvW-1:0]     fs_q;
  logic [MvW-1:0]     mv_q, mv_d;
  logic [3:0]         digits_q [4];
  logic [3:0]         digits_d [4];
  logic [1:0]         scan_q;

  logic in_accept, out_free, c_tick, c_leave, c_free, b_move, b_free, a_move, a_free;
  logic mv_load, digits_load, out_load;

  logic [ProdW-1:0]        prod;
  logic [ProdW+RecipW-1:0] recip_prod;
  logic [QuotW-1:0]        q_est, q_fix;
  logic [ProdW-1:0]        rem;

  logic [29:0] p10;
  logic [26:0] p100;
  logic [28:0] p1000;
  logic [10:0] q10;
  logic [7:0]  q100;
  logic [4:0]  q1000;

  logic [1:0] pos;
  logic       digit_on;

  // handshake and pipeline flow
  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign c_tick    = c_valid_q && (c_cmd_q == CmdTick);
  assign c_leave   = c_valid_q && ((c_cmd_q == CmdSample) || out_free);
  assign c_free    = !c_valid_q || c_leave;
  assign b_move    = b_valid_q && c_free;
  assign b_free    = !b_valid_q || c_free;
  assign a_move    = a_valid_q && b_free;
  assign a_free    = !a_valid_q || b_free;
  assign in_ready_o = a_free;

  assign mv_load     = b_move && (b_cmd_q == CmdSample);
  assign digits_load = c_valid_q && (c_cmd_q == CmdSample);
  assign out_load    = c_tick && out_free;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_accept) begin
      a_valid_d = 1'b1;
    end else if (a_move) begin
      a_valid_d = 1'b0;
    end
    b_valid_d = b_valid_q;
    if (a_move) begin
      b_valid_d = 1'b1;
    end else if (b_move) begin
      b_valid_d = 1'b0;
    end
    c_valid_d = c_valid_q;
    if (b_move) begin
      c_valid_d = 1'b1;
    end else if (c_leave) begin
      c_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // scale: reading times full scale
  assign prod = ProdW'(a_sample_q) * ProdW'(fs_q);

  // divide by the converter maximum, correct once, saturate
  always_comb begin
    recip_prod = (ProdW+RecipW)'(b_prod_q) * (ProdW+RecipW)'(Recip);
    q_est      = recip_prod[RecipShift +: QuotW];
    rem        = b_prod_q - ((ProdW'(q_est) << AdcBits) - ProdW'(q_est));
    q_fix      = q_est + QuotW'(rem >= ProdW'(ConvMax));
    if (int'(q_fix) > int'(MvLimit)) begin
      mv_d = MvLimit;
    end else begin
      mv_d = MvW'(q_fix);
    end
  end

  // split the stored value into decimal digits
  always_comb begin
    p10   = 30'(mv_q) * 30'(Div10Mul);
    p100  = 27'(mv_q) * 27'(Div100Mul);
    p1000 = 29'(mv_q) * 29'(Div1000Mul);
    q10   = p10[Div10Shift +: 11];
    q100  = p100[Div100Shift +: 8];
    q1000 = p1000[Div1000Shift +: 5];
    digits_d[0] = 4'(mv_q - (14'({q10, 3'b000}) + 14'({q10, 1'b0})));
    digits_d[1] = 4'(q10 - ({q100, 3'b000} + 11'({q100, 1'b0})));
    digits_d[2] = 4'(q100 - ({q1000, 3'b000} + 8'({q1000, 1'b0})));
    digits_d[3] = 4'(q1000);
  end

  // advance the scan and build the output word
  assign pos = scan_q + 2'd1;

  always_comb begin
    unique case (pos_e'(pos))
      PosUnits:     digit_on = 1'b1;
      PosTens:      digit_on = (mv_q >= PlaceTens);
      PosHundreds:  digit_on = (mv_q >= PlaceHundreds);
      PosThousands: digit_on = (mv_q >= PlaceThousands);
      default:      digit_on = 1'b0;
    endcase
    out_data_d.segments     = seg_pattern(digits_q[pos]);
    out_data_d.digit_enable = digit_on ? (4'd1 << pos) : 4'd0;
    out_data_d.digit_index  = pos;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fs_q        <= FullScaleReset;
      mv_q        <= '0;
      scan_q      <= PosUnits;
      for (int i = 0; i < 4; i++) begin
        digits_q[i] <= '0;
      end
    end else begin
      a_valid_q   <= a_valid_d;
      b_valid_q   <= b_valid_d;
      c_valid_q   <= c_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        fs_q <= cfg_data_i;
      end
      if (mv_load) begin
        mv_q <= mv_d;
      end
      if (digits_load) begin
        for (int i = 0; i < 4; i++) begin
          digits_q[i] <= digits_d[i];
        end
      end
      if (out_load) begin
        scan_q <= pos;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_cmd_q    <= in_data_i.command;
      a_sample_q <= in_data_i.sample;
    end
    if (a_move) begin
      b_cmd_q  <= a_cmd_q;
      b_prod_q <= prod;
    end
    if (b_move) begin
      c_cmd_q <= b_cmd_q;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_ALWAYS(a_mv_limit, (mv_q <= MvLimit) && (digits_q[3] <= 4'd9), "value above limit")
  `ASSERT_IMPL(a_enable_match, out_valid_o, (out_data_o.digit_enable == 4'd0) || (out_data_o.digit_enable == (4'd1 << out_data_o.digit_index)), "enable does not match index")
  `ASSERT_IMPL(a_units_shown, out_valid_o && (out_data_o.digit_index == PosUnits), out_data_o.digit_enable == 4'd1, "units digit blanked")
  `ASSERT_NEXT(a_scan_follows, out_load, out_data_o.digit_index == scan_q, "scan position out of step")

endmodule

/* tb/adc_millivolt_seven_segment_scanner_unit_test.sv */
// Testbench for the millivolt seven-segment scanner: random traffic checked against a digit model
`timescale 1ns / 1ps
module adc_millivolt_seven_segment_scanner_unit_test;
  import amss_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxGap = 12;
  localparam int unsigned WordsPerPhase = 95;
  localparam int unsigned NumSettings = 8;
  localparam int unsigned PressurePhase = 4;
  localparam logic [7:0] DigitGlyph [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  in_word_t        in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  out_word_t       out_data_o;
  logic            cfg_we_i = 1'b0;
  logic [MvW-1:0]  cfg_data_i = FullScaleReset;

  in_word_t        pending_words [$];
  out_word_t       expected_readouts [$];

  logic [MvW-1:0]  model_full_scale = FullScaleReset;
  logic [MvW-1:0]  model_millivolts = '0;
  pos_e            model_scan = PosUnits;

  int unsigned     words_loaded = 0;
  int unsigned     words_taken = 0;
  int unsigned     ticks_sent = 0;
  int unsigned     samples_sent = 0;
  int unsigned     readouts_checked = 0;
  int unsigned     readout_errors = 0;
  int unsigned     idle_cycles = 0;
  int unsigned     send_gap = 0;
  int unsigned     recv_gap = 0;
  int unsigned     hold_left = 0;
  bit              send_idle_on = 1'b1;
  bit              recv_idle_on = 1'b1;
  bit              hold_request = 1'b0;
  bit              offer;
  bit              ready_next;

  adc_millivolt_seven_segment_scanner_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic predict_readout(input in_word_t w);
    int unsigned scaled;
    int unsigned place;
    int unsigned digit;
    logic [1:0] next_pos;
    out_word_t r;
    if (w.command == CmdSample) begin
      scaled = (32'(w.sample) * 32'(model_full_scale)) / ConvMax;
      if (scaled > MvLimit) scaled = MvLimit;
      model_millivolts = MvW'(scaled);
      samples_sent++;
    end else begin
      next_pos = model_scan + 2'd1;
      model_scan = pos_e'(next_pos);
      case (model_scan)
        PosUnits:     place = 1;
        PosTens:      place = PlaceTens;
        PosHundreds:  place = PlaceHundreds;
        default:      place = PlaceThousands;
      endcase
      digit = (model_millivolts / place) % 10;
      r.segments = DigitGlyph[digit];
      r.digit_enable = (model_scan == PosUnits || model_millivolts >= place) ?
                       (4'b0001 << model_scan) : 4'b0000;
      r.digit_index = model_scan;
      expected_readouts.push_back(r);
      ticks_sent++;
    end
  endtask

  task automatic compare_readout(input out_word_t got);
    out_word_t want;
    if (expected_readouts.size() == 0) begin
      readout_errors++;
      if (readout_errors <= 10) $display("Unexpected readout word %h", got);
    end else begin
      want = expected_readouts.pop_front();
      if (got.segments !== want.segments || got.digit_enable !== want.digit_enable ||
          got.digit_index !== want.digit_index) begin
        readout_errors++;
        if (readout_errors <= 10)
          $display("Readout %0d: expected seg %h en %b idx %0d, got seg %h en %b idx %0d",
                   readouts_checked, want.segments, want.digit_enable, want.digit_index,
                   got.segments, got.digit_enable, got.digit_index);
      end
    end
    readouts_checked++;
  endtask

  task automatic load_word(input cmd_e c, input logic [SampleW-1:0] s);
    in_word_t w;
    w.command = c;
    w.sample = s;
    pending_words.push_back(w);
    words_loaded++;
  endtask

  function automatic logic [SampleW-1:0] draw_reading();
    case ($urandom_range(0, 7))
      0:       return SampleW'($urandom_range(0, 15));
      1:       return SampleW'(ConvMax - $urandom_range(0, 15));
      default: return SampleW'($urandom_range(0, ConvMax));
    endcase
  endfunction

  task automatic load_random_words(input int unsigned count);
    int unsigned n;
    int unsigned burst;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 4) != 0) begin
        load_word(CmdSample, draw_reading());
        burst = $urandom_range(1, 8);
        n += burst + 1;
        repeat (burst) load_word(CmdTick, SampleW'($urandom));
      end else begin
        if ($urandom_range(0, 1) != 0) load_word(CmdSample, SampleW'($urandom));
        else load_word(CmdTick, SampleW'($urandom));
        n++;
      end
    end
  endtask

  task automatic wait_for_idle();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || words_taken != words_loaded ||
           expected_readouts.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_full_scale(input logic [MvW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= value;
    model_full_scale = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      offer = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_readout(in_data_i);
        words_taken++;
        offer = 1'b0;
        send_gap = send_idle_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (pending_words.size() != 0) begin
          in_data_i <= pending_words.pop_front();
          offer = 1'b1;
        end
      end
      in_valid_i <= offer;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        compare_readout(out_data_o);
        recv_gap = recv_idle_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (hold_request) begin
        hold_left = LongHold;
        hold_request = 1'b0;
      end
      ready_next = 1'b0;
      if (hold_left != 0) begin
        hold_left--;
      end else if (recv_gap != 0) begin
        recv_gap--;
      end else begin
        ready_next = 1'b1;
      end
      out_ready_i <= ready_next;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == WatchdogLimit) begin
          $display("Watchdog: no handshake for %0d cycles, %0d readouts outstanding",
                   WatchdogLimit, expected_readouts.size());
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [MvW-1:0] full_scale_plan [NumSettings];
    int unsigned p;
    full_scale_plan = '{MvW'(9999), MvW'(0), MvW'(16383), MvW'(1023),
                        MvW'($urandom_range(0, 9999)), MvW'(1),
                        MvW'($urandom_range(0, 16383)), FullScaleReset};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // blank digits from reset, full-scale reading, smallest nonzero reading
    load_word(CmdTick, '0);
    load_word(CmdTick, '1);
    load_word(CmdTick, '0);
    load_word(CmdTick, '1);
    load_word(CmdSample, SampleW'(ConvMax));
    repeat (4) load_word(CmdTick, '0);
    load_word(CmdSample, SampleW'(1));
    repeat (2) load_word(CmdTick, '1);
    load_random_words(WordsPerPhase);
    wait_for_idle();

    for (p = 0; p < NumSettings; p++) begin
      write_full_scale(full_scale_plan[p]);
      send_idle_on = (p % 3 != 2) && (p != PressurePhase);
      recv_idle_on = (p % 3 != 2);
      if (p == 0) begin
        load_word(CmdSample, SampleW'(ConvMax));
        repeat (4) load_word(CmdTick, '0);
      end else if (p == 2) begin
        load_word(CmdSample, SampleW'(ConvMax));
        load_word(CmdTick, '0);
        load_word(CmdSample, SampleW'(700));
        repeat (4) load_word(CmdTick, '1);
      end
      if (p == PressurePhase) hold_request = 1'b1;
      load_random_words(WordsPerPhase);
      wait_for_idle();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (expected_readouts.size() != 0) readout_errors += expected_readouts.size();
    $display("Covered %0d scan ticks and %0d samples over %0d full-scale settings,",
             ticks_sent, samples_sent, NumSettings + 1);
    $display("with random idling on both sides and one %0d-cycle output hold",
             LongHold);
    if (readout_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
